// File: rtl/core/rpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpb_pkg;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned AddrW = $clog2(MaxVertices);
  localparam int unsigned CntW = $clog2(MaxVertices + 1);
  localparam int unsigned CordicSteps = 16;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
  localparam logic signed [17:0] PiQ13 = 18'sd25736;
  localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;
  localparam logic [15:0] CordicGain = 16'd39797;
  // 2*pi in Q3.13 is 16 * 3217: reduce by the odd factor with a reciprocal
  localparam logic [11:0] ModOdd = 12'd3217;
  localparam logic [31:0] ModRecip = 32'((64'd1 << 43) / 64'd3217);
  // multiple of 2*pi that makes any angle sum positive
  localparam logic [35:0] WrapBias = 36'd51472 << 19;

  typedef enum logic [2:0] {
    RegOriginX = 3'd0, RegOriginY = 3'd1, RegCentreAngle = 3'd2,
    RegArcSpan = 3'd3, RegRadiusOffset = 3'd4, RegTaperGain = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [15:0] ang;
    logic signed [15:0] arc;
    logic signed [15:0] off;
    logic signed [15:0] corr;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
  } box_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0: atan_q16 = 20'sd51472;
      4'd1: atan_q16 = 20'sd30386;
      4'd2: atan_q16 = 20'sd16055;
      4'd3: atan_q16 = 20'sd8150;
      4'd4: atan_q16 = 20'sd4091;
      4'd5: atan_q16 = 20'sd2047;
      4'd6: atan_q16 = 20'sd1024;
      4'd7: atan_q16 = 20'sd512;
      4'd8: atan_q16 = 20'sd256;
      4'd9: atan_q16 = 20'sd128;
      4'd10: atan_q16 = 20'sd64;
      4'd11: atan_q16 = 20'sd32;
      4'd12: atan_q16 = 20'sd16;
      4'd13: atan_q16 = 20'sd8;
      4'd14: atan_q16 = 20'sd4;
      default: atan_q16 = 20'sd2;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/radial_polyline_bend.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: one vertex per cycle, busy stays low while loading.
// Emission after the last vertex, per vertex: store read and issue, two serial
// divides (skipped for a flat polyline), 8 setup steps, 16 CORDIC steps and output;
// the store read and issue are in this module, the rest in rpb_bend.
// Results appear one per vertex with result_valid_o high for one cycle.
// Asynchronous active-low reset clears count, box, config and control state; the
// store and the output data registers are not cleared. The receiver cannot stall.
module radial_polyline_bend (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] vert_x_i,
  input  wire logic signed [31:0] vert_y_i,
  input  wire logic               vert_last_i,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic                    out_last_o
);
  import rpb_pkg::*;
  typedef enum logic [1:0] {SLoad, SRead, SIssue, SRun} state_e;
  state_e state_q;
  cfg_t cfg_q;
  box_t box_q;
  logic [CntW-1:0]  cnt_q;
  logic [AddrW-1:0] rd_q;
  logic [63:0]      rdata;
  logic             acc, we, bdone, bstart;
  logic signed [31:0] bx, by;

  assign acc = start && !busy;
  assign we = acc && (cnt_q < CntW'(MaxVertices));
  assign bstart = (state_q == SIssue);

  rpb_store u_store (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i({vert_x_i, vert_y_i}), .raddr_i(rd_q), .rdata_o(rdata)
  );
  rpb_bend u_bend (
    .clk_i, .rst_ni, .start_i(bstart), .vert_i(rdata), .box_i(box_q),
    .cfg_i(cfg_q), .done_o(bdone), .ox_o(bx), .oy_o(by)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      busy <= 1'b0;
      cnt_q <= '0;
      rd_q <= '0;
      box_q <= {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
      cfg_q <= '{32'sd0, 32'sd0, 16'sd0, 16'sd25736, 16'sd0, 16'sd0};
      result_valid_o <= 1'b0;
      out_last_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegOriginX: cfg_q.org_x <= cfg_data_i;
          RegOriginY: cfg_q.org_y <= cfg_data_i;
          RegCentreAngle: cfg_q.ang <= cfg_data_i[15:0];
          RegArcSpan: cfg_q.arc <= cfg_data_i[15:0];
          RegRadiusOffset: cfg_q.off <= cfg_data_i[15:0];
          RegTaperGain: cfg_q.corr <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (state_q)
        SLoad: if (acc) begin
          if (we) begin
            cnt_q <= cnt_q + CntW'(1);
            if (vert_x_i < box_q.min_x) box_q.min_x <= vert_x_i;
            if (vert_x_i > box_q.max_x) box_q.max_x <= vert_x_i;
            if (vert_y_i < box_q.min_y) box_q.min_y <= vert_y_i;
            if (vert_y_i > box_q.max_y) box_q.max_y <= vert_y_i;
          end
          if (vert_last_i && (we || cnt_q != '0)) begin
            busy <= 1'b1;
            rd_q <= '0;
            state_q <= SRead;
          end
        end
        // SRead lets the registered store read settle so the data is valid at issue
        SRead: state_q <= SIssue;
        SIssue: state_q <= SRun;
        SRun: if (bdone) begin
          result_valid_o <= 1'b1;
          out_x_o <= bx;
          out_y_o <= by;
          out_last_o <= (CntW'(rd_q) + CntW'(1) == cnt_q);
          if (CntW'(rd_q) + CntW'(1) == cnt_q) begin
            busy <= 1'b0;
            cnt_q <= '0;
            box_q <= {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
            state_q <= SLoad;
          end else begin
            rd_q <= rd_q + AddrW'(1);
            state_q <= SRead;
          end
        end
        default: state_q <= SLoad;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxVertices)) else $error("count overflow");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result while idle");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_last_o) |-> !busy) else $error("last without release");
endmodule
`default_nettype wire

// File: rtl/core/rpb_store.sv
`timescale 1ns / 1ps
`default_nettype none
module rpb_store (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [rpb_pkg::AddrW-1:0] waddr_i,
  input  wire logic [63:0]              wdata_i,
  input  wire logic [rpb_pkg::AddrW-1:0] raddr_i,
  output logic [63:0]                   rdata_o
);
  import rpb_pkg::*;
  logic [63:0] mem [MaxVertices];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/rpb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle; unsigned 50/33 bits.
module rpb_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [49:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [49:0]      quo_o
);
  import rpb_pkg::*;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [33:0] rem_q;
  logic [49:0] quo_q;
  logic [32:0] den_q;
  logic [33:0] trial;
  assign trial = {rem_q[32:0], quo_q[49]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd50;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[48:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[48:0], 1'b0};
      end
    end
  end
  assign quo_o = quo_q;
endmodule
`default_nettype wire

// File: rtl/core/rpb_bend.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequences one vertex: two divides (skipped for zero box height), products, angle fold, 16 CORDIC steps.
module rpb_bend (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [63:0]     vert_i,
  input  wire rpb_pkg::box_t   box_i,
  input  wire rpb_pkg::cfg_t   cfg_i,
  output logic                 done_o,
  output logic signed [31:0]   ox_o,
  output logic signed [31:0]   oy_o
);
  import rpb_pkg::*;
  typedef enum logic [3:0] {
    SIdle, SDivT, SWaitT, SDivR, SWaitR, SOffs, SS21, STheta, SWrap, SMod, SFold,
    SRad, SGain, SCordic, SOut
  } state_e;
  state_e state_q;
  logic signed [31:0] x_q, y_q;
  logic signed [33:0] h;
  logic signed [17:0] t_q;
  logic signed [32:0] ratio_q;
  logic signed [35:0] offs_q;
  logic signed [31:0] s21_q;
  logic signed [35:0] theta_q;
  logic signed [19:0] z_q;
  logic               neg_q;
  logic signed [63:0] r_q;
  logic signed [39:0] cx_q, cy_q;
  logic [3:0]         it_q;
  logic               dstart;
  logic [49:0]        dnum, dquo;
  logic               ddone;
  logic               rneg_q;
  logic signed [34:0] dxs;
  logic [34:0]        dxa;
  logic [35:0]        wrap_u;
  logic [63:0]        wrap_prod;
  logic [31:0]        wrap_v_q;
  logic [3:0]         wrap_lo_q;
  logic [20:0]        wrap_qe_q;
  logic [31:0]        wrap_r;
  logic [11:0]        wrap_a;
  logic signed [39:0] ddx, ddy;
  logic signed [19:0] at;
  logic signed [64:0] gprod;
  logic signed [49:0] t_nom;

  function automatic logic signed [31:0] sat(input logic signed [40:0] v);
    if (v > 41'sd2147483647) sat = 32'sh7fffffff;
    else if (v < -41'sd2147483648) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  assign h = 34'(box_i.max_y) - 34'(box_i.min_y);
  assign dxs = 35'(x_q) + 35'(x_q) - 35'(box_i.min_x) - 35'(box_i.max_x);
  assign dxa = dxs[34] ? 35'(-dxs) : dxs;
  assign t_nom = 50'(35'(y_q) - 35'(box_i.min_y)) <<< 16;
  assign dnum = (state_q == SDivT) ? t_nom : (50'(dxa) << 15);
  assign dstart = (state_q == SDivT) || (state_q == SDivR);
  // angle mod 2*pi: low 4 bits pass, the rest is reduced by 3217
  assign wrap_u = 36'(theta_q) + WrapBias;
  assign wrap_prod = 64'(wrap_u[35:4]) * 64'(ModRecip);
  assign wrap_r = wrap_v_q - 32'(wrap_qe_q) * 32'(ModOdd);
  assign wrap_a = (wrap_r >= 32'(ModOdd)) ? 12'(wrap_r - 32'(ModOdd)) : wrap_r[11:0];
  assign ddx = cy_q >>> it_q;
  assign ddy = cx_q >>> it_q;
  assign at = atan_q16(it_q);
  assign gprod = $signed(r_q[47:0]) * $signed({1'b0, CordicGain});

  rpb_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(h[32:0]),
    .done_o(ddone), .quo_o(dquo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        SIdle: if (start_i) begin
          x_q <= vert_i[63:32];
          y_q <= vert_i[31:0];
          state_q <= SDivT;
        end
        SDivT: begin
          if (h == 34'sd0) begin
            t_q <= 18'sd65536;
            ratio_q <= -33'sd65536;
            state_q <= SOffs;
          end else begin
            state_q <= SWaitT;
          end
        end
        SWaitT: if (ddone) begin
          t_q <= 18'sd65536 - 18'(dquo);
          state_q <= SDivR;
          rneg_q <= dxs[34];
        end
        SDivR: state_q <= SWaitR;
        SWaitR: if (ddone) begin
          if (dquo > 50'd2147483648) ratio_q <= rneg_q ? -33'sd2147483648 : 33'sd2147483648;
          else ratio_q <= rneg_q ? -33'(dquo) : 33'(dquo);
          state_q <= SOffs;
        end
        SOffs: begin
          offs_q <= 36'sd134217728 - 36'(t_q) * 36'(cfg_i.corr);
          state_q <= SS21;
        end
        SS21: begin
          s21_q <= 32'((52'(cfg_i.arc) * 52'(offs_q)) >>> 20);
          state_q <= STheta;
        end
        STheta: begin
          theta_q <= 36'(cfg_i.ang) + 36'((65'(s21_q) * 65'(ratio_q)) >>> 24);
          state_q <= SWrap;
        end
        SWrap: begin
          wrap_v_q <= wrap_u[35:4];
          wrap_lo_q <= wrap_u[3:0];
          wrap_qe_q <= wrap_prod[63:43];
          state_q <= SMod;
        end
        SMod: begin
          theta_q <= 36'({wrap_a, wrap_lo_q});
          state_q <= SFold;
        end
        SFold: begin
          neg_q <= 1'b0;
          if (theta_q >= PiQ13) begin
            if (theta_q - TwoPiQ13 < -HalfPiQ13) begin
              z_q <= 20'((theta_q - TwoPiQ13 + PiQ13) * 8);
              neg_q <= 1'b1;
            end else z_q <= 20'((theta_q - TwoPiQ13) * 8);
          end else if (theta_q > HalfPiQ13) begin
            z_q <= 20'((theta_q - PiQ13) * 8);
            neg_q <= 1'b1;
          end else z_q <= 20'(theta_q * 8);
          state_q <= SRad;
        end
        SRad: begin
          r_q <= (64'(t_q) + 64'(cfg_i.off) * 64'sd16) * 64'(h) >>> 16;
          state_q <= SGain;
        end
        SGain: begin
          cx_q <= 40'(gprod >>> 16);
          cy_q <= '0;
          it_q <= '0;
          state_q <= SCordic;
        end
        SCordic: begin
          if (!z_q[19]) begin
            cx_q <= cx_q - ddx; cy_q <= cy_q + ddy; z_q <= z_q - at;
          end else begin
            cx_q <= cx_q + ddx; cy_q <= cy_q - ddy; z_q <= z_q + at;
          end
          it_q <= it_q + 4'd1;
          if (it_q == 4'(CordicSteps - 1)) state_q <= SOut;
        end
        SOut: begin
          done_o <= 1'b1;
          ox_o <= sat(41'(cfg_i.org_x) + (neg_q ? -41'(cx_q) : 41'(cx_q)));
          oy_o <= sat(41'(cfg_i.org_y) + (neg_q ? -41'(cy_q) : 41'(cy_q)));
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
